// ===== rtl/ovca_pkg.sv =====
// Shared types and constants of the output channel allocator with escape channels and credits.
`default_nettype none

package ovca_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned VnetW      = 2;
  localparam int unsigned VcW        = 4;
  localparam int unsigned FreeCntW   = 3;
  localparam int unsigned FreeCntMax = 7;

  // Kinds of input item.
  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_PROBE  = 2'd1,
    REQ_CREDIT = 2'd2,
    REQ_SENT   = 2'd3
  } req_type_e;

  // One input item.
  typedef struct packed {
    req_type_e        req_type;
    logic [VnetW-1:0] vnet;
    logic [VcW-1:0]   in_vc;
    logic             is_head;
    logic             updown_here;
    logic [VcW-1:0]   target_vc;
    logic             free_flag;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                grant;
    logic [VcW-1:0]      granted_vc;
    logic                mark_new_source;
    logic [FreeCntW-1:0] free_count;
    logic                credit_available;
    logic                credit_error;
  } out_item_t;

  // Outcome of the channel selection.
  typedef struct packed {
    logic           grant;
    logic [VcW-1:0] granted_vc;
    logic           mark_new_source;
  } sel_t;

endpackage

`default_nettype wire

// ===== rtl/ovca_select.sv =====
// Channel selection: picks the lowest eligible idle channel of a virtual network.
`default_nettype none

module ovca_select import ovca_pkg::*; #(
  parameter int unsigned VCS_PER_VNET = 4,
  parameter int unsigned NUM_VNETS    = 4
) (
  input  logic [VCS_PER_VNET*NUM_VNETS-1:0] active_i,
  input  logic                              escape_en_i,
  input  in_item_t                          item_i,
  output sel_t                              sel_o,
  output logic [FreeCntW-1:0]               free_count_o
);

  localparam int unsigned CntW = $clog2(VCS_PER_VNET + 1);

  logic [VCS_PER_VNET-1:0] grp_idle;
  logic [VCS_PER_VNET-1:0] elig;
  logic                    vnet_ok;
  logic                    esc_req;
  logic [VcW-1:0]          base;
  logic                    found;
  logic [VcW-1:0]          pick;
  logic [CntW-1:0]         idle_cnt;

  // Gather the idle bits of the requested virtual network.
  always_comb begin
    grp_idle = '0;
    vnet_ok  = 1'b0;
    esc_req  = 1'b0;
    base     = '0;
    for (int v = 0; v < NUM_VNETS; v++) begin
      if (int'(item_i.vnet) == v) begin
        vnet_ok  = 1'b1;
        grp_idle = ~active_i[v*VCS_PER_VNET +: VCS_PER_VNET];
        base     = VcW'(v * VCS_PER_VNET);
        esc_req  = int'(item_i.in_vc) == v * VCS_PER_VNET + VCS_PER_VNET - 1;
      end
    end
  end

  // Apply the escape channel rules to the idle set.
  always_comb begin
    elig = grp_idle;
    if (escape_en_i) begin
      priority if (esc_req) begin
        elig = '0;
        elig[VCS_PER_VNET-1] = grp_idle[VCS_PER_VNET-1];
      end else if (!item_i.is_head) begin
        elig = '0;
      end else if (!item_i.updown_here) begin
        elig[VCS_PER_VNET-1] = 1'b0;
      end else begin
        elig = grp_idle;
      end
    end
  end

  // Lowest eligible channel wins.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = VCS_PER_VNET - 1; i >= 0; i--) begin
      if (elig[i]) begin
        found = 1'b1;
        pick  = VcW'(i);
      end
    end
  end

  // A head flit off the escape channel that lands on it becomes a new source.
  always_comb begin
    sel_o.grant           = vnet_ok && found;
    sel_o.granted_vc      = sel_o.grant ? base + pick : '0;
    sel_o.mark_new_source = sel_o.grant && escape_en_i && !esc_req &&
                            (int'(pick) == VCS_PER_VNET - 1);
  end

  // Idle count of the virtual network, saturated to the field width.
  always_comb begin
    idle_cnt = CntW'($countones(grp_idle));
    if (int'(idle_cnt) > FreeCntMax) begin
      free_count_o = FreeCntW'(FreeCntMax);
    end else begin
      free_count_o = FreeCntW'(idle_cnt);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/output_vc_allocator_escape_credit_unit.sv =====
// Top level: output port channel allocator with escape channels and credit tracking.
//
// Usage: each item on the input channel (in_valid_i/in_ready_o, in_item_i) is an
// allocation, a probe, a credit return or a flit-sent notice for this output port.
// Every item produces exactly one result item on the output channel
// (out_valid_o/out_ready_i, out_item_o) in the order the items arrived.
// The one-bit escape mode register is written through cfg_valid_i/cfg_data_i;
// cfg_ready_o is always high and writes are expected only while the block is idle.
// An accepted item is captured in the input register, then processed and captured
// in the result register once that register can take it; its result is offered
// from there. Throughput is one item per cycle while the receiver does not stall:
// the read, modify and write of the active bits and credit counts all happen in the
// single stage between the input and result registers.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item; after that in_ready_o drops until the result moves.
// Reset empties both registers, sets every channel idle with a full credit count,
// and turns escape mode off.
`default_nettype none

module output_vc_allocator_escape_credit_unit import ovca_pkg::*; #(
  parameter int unsigned VCS_PER_VNET   = 4,
  parameter int unsigned NUM_VNETS      = 4,
  parameter int unsigned BUFFERS_PER_VC = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned NumCh = VCS_PER_VNET * NUM_VNETS;
  localparam int unsigned ChW   = $clog2(NumCh);
  localparam int unsigned CrW   = $clog2(BUFFERS_PER_VC + 1);

  logic                 escape_q;
  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  logic                 s1_fire;
  logic                 out_valid_q;
  out_item_t            out_item_q;
  out_item_t            out_item_d;
  logic [NumCh-1:0]     active_q;
  logic [NumCh-1:0]     active_d;
  logic [CrW-1:0]       credits_q [NumCh];
  logic [CrW-1:0]       credits_d [NumCh];
  sel_t                 sel;
  logic [FreeCntW-1:0]  free_count;
  logic                 tvalid;
  logic [ChW-1:0]       tidx;
  logic [ChW-1:0]       gidx;
  logic [CrW-1:0]       cur;
  logic [CrW-1:0]       cr_new;
  logic                 cr_err;
  logic                 is_select;

  // Configuration register; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      escape_q <= cfg_data_i;
    end
  end

  // Input register; it moves on whenever the result register can take an item.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // Channel selection over the current active bits.
  ovca_select #(
    .VCS_PER_VNET (VCS_PER_VNET),
    .NUM_VNETS    (NUM_VNETS)
  ) u_select (
    .active_i     (active_q),
    .escape_en_i  (escape_q),
    .item_i       (s1_item_q),
    .sel_o        (sel),
    .free_count_o (free_count)
  );

  // Credit lookup for the target channel.
  assign tvalid    = int'(s1_item_q.target_vc) < NumCh;
  assign tidx      = ChW'(s1_item_q.target_vc);
  assign gidx      = ChW'(sel.granted_vc);
  assign cur       = tvalid ? credits_q[tidx] : '0;
  assign is_select = (s1_item_q.req_type == REQ_ALLOC) || (s1_item_q.req_type == REQ_PROBE);

  // Saturating credit update.
  always_comb begin
    cr_new = cur;
    cr_err = 1'b0;
    unique case (s1_item_q.req_type)
      REQ_CREDIT: begin
        if (int'(cur) >= BUFFERS_PER_VC) begin
          cr_err = 1'b1;
        end else begin
          cr_new = cur + 1'b1;
        end
      end
      REQ_SENT: begin
        if (cur == '0) begin
          cr_err = 1'b1;
        end else begin
          cr_new = cur - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!tvalid) begin
      cr_err = 1'b0;
    end
  end

  // Next state of active bits and credit counts.
  always_comb begin
    active_d  = active_q;
    credits_d = credits_q;
    if (s1_fire) begin
      if (s1_item_q.req_type == REQ_ALLOC && sel.grant) begin
        active_d[gidx] = 1'b1;
      end
      if (s1_item_q.req_type == REQ_CREDIT && tvalid && s1_item_q.free_flag) begin
        active_d[tidx] = 1'b0;
      end
      if (!is_select && tvalid) begin
        credits_d[tidx] = cr_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      credits_q <= '{default: CrW'(BUFFERS_PER_VC)};
    end else begin
      active_q  <= active_d;
      credits_q <= credits_d;
    end
  end

  // Assemble the result item.
  always_comb begin
    out_item_d.grant            = is_select && sel.grant;
    out_item_d.granted_vc       = is_select ? sel.granted_vc : '0;
    out_item_d.mark_new_source  = is_select && sel.mark_new_source;
    out_item_d.free_count       = free_count;
    out_item_d.credit_available = tvalid && (cur != '0);
    out_item_d.credit_error     = !is_select && cr_err;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // A credit count never exceeds the buffer depth.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && tvalid |-> int'(cur) <= BUFFERS_PER_VC)
    else $error("credit count above buffer depth");

  // A granted channel was idle when it was chosen.
  a_grant_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && sel.grant |-> !active_q[gidx])
    else $error("granted channel was already active");

  // An allocation marks its channel active.
  a_alloc_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_item_q.req_type == REQ_ALLOC && sel.grant |=> active_q[$past(gidx)])
    else $error("allocated channel not active");

  // A new source mark comes only with a grant.
  a_mark_needs_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mark_new_source |-> out_item_o.grant)
    else $error("new source mark without grant");

  // A credit error never comes with a grant.
  a_err_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.credit_error |-> !out_item_o.grant)
    else $error("credit error on a granting item");
`endif

endmodule

`default_nettype wire
